>>> rtl/msc_pkg.sv
`default_nettype none
package msc_pkg;

    localparam int DEF_NUM_CACHES = 4;
    localparam int DEF_LINES      = 64;
    localparam int DEF_ADDR_BITS  = 32;

    // widest line index (LINES up to 4096) and widest cache mask (up to 16 caches)
    localparam int IDX_W    = 12;
    localparam int MAXC     = 16;
    localparam int TAG_W    = 32;
    localparam int AGE_W    = 32;
    localparam int OFF_W    = 4;
    localparam logic [OFF_W-1:0] OFF_RESET = 4'd6;

    typedef enum logic [1:0] {
        ST_I = 2'd0,
        ST_S = 2'd1,
        ST_E = 2'd2,
        ST_M = 2'd3
    } t_mesi;

    typedef enum logic [1:0] {
        BUS_NONE = 2'd0,
        BUS_RD   = 2'd1,
        BUS_RDX  = 2'd2,
        BUS_UPGR = 2'd3
    } t_bus;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_APPLY
    } t_fsm;

    localparam logic CMD_WRITE = 1'b1;

    // running lookup record handed from cell to cell
    typedef struct packed {
        logic             own_hit;
        logic [IDX_W-1:0] own_idx;
        t_mesi            own_state;
        logic             inv_found;
        logic [IDX_W-1:0] inv_idx;
        logic [AGE_W-1:0] min_age;
        logic [IDX_W-1:0] min_idx;
        logic [TAG_W-1:0] min_tag;
        logic             min_m;
        logic [MAXC-1:0]  match_mask;
        logic [MAXC-1:0]  m_mask;
    } t_rec;

    // update broadcast to every cell at the end of a transaction
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             alloc;
        t_mesi            state;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] stamp;
        logic             remote_en;
        t_mesi            remote_state;
    } t_upd;

endpackage
`default_nettype wire

>>> rtl/msc_cell.sv
`default_nettype none
module msc_cell #(
    parameter int NUM_CACHES = msc_pkg::DEF_NUM_CACHES,
    parameter int IDX        = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [1:0]              i_req,
    input  wire logic [msc_pkg::TAG_W-1:0] i_tag,
    input  wire msc_pkg::t_rec           i_rec,
    output msc_pkg::t_rec                o_rec,
    input  wire msc_pkg::t_upd           i_upd
);
    import msc_pkg::*;

    logic [TAG_W-1:0] r_tag   [NUM_CACHES];
    logic [AGE_W-1:0] r_age   [NUM_CACHES];
    t_mesi            r_state [NUM_CACHES];
    t_rec             r_rec;
    t_rec             n_rec;
    logic [NUM_CACHES-1:0] w_match;

    always_comb begin
        n_rec = i_rec;
        for (int c = 0; c < NUM_CACHES; c++) begin
            w_match[c] = (r_state[c] != ST_I) && (r_tag[c] == i_tag);
            if (32'(c) == 32'(i_req)) begin
                if (w_match[c] && !n_rec.own_hit) begin
                    n_rec.own_hit   = 1'b1;
                    n_rec.own_idx   = IDX_W'(IDX);
                    n_rec.own_state = r_state[c];
                end
                if (r_state[c] == ST_I && !n_rec.inv_found) begin
                    n_rec.inv_found = 1'b1;
                    n_rec.inv_idx   = IDX_W'(IDX);
                end
                // ties go to the later line
                if (r_age[c] <= n_rec.min_age) begin
                    n_rec.min_age = r_age[c];
                    n_rec.min_idx = IDX_W'(IDX);
                    n_rec.min_tag = r_tag[c];
                    n_rec.min_m   = (r_state[c] == ST_M);
                end
            end else begin
                n_rec.match_mask[c] = n_rec.match_mask[c] | w_match[c];
                n_rec.m_mask[c]     = n_rec.m_mask[c] | (w_match[c] && r_state[c] == ST_M);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CACHES; c++) begin
                r_state[c] <= ST_I;
            end
        end else if (i_upd.en) begin
            for (int c = 0; c < NUM_CACHES; c++) begin
                if (32'(c) == 32'(i_req)) begin
                    if (i_upd.idx == IDX_W'(IDX)) begin
                        r_state[c] <= i_upd.state;
                    end
                end else if (w_match[c] && i_upd.remote_en) begin
                    r_state[c] <= i_upd.remote_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            for (int c = 0; c < NUM_CACHES; c++) begin
                if (32'(c) == 32'(i_req) && i_upd.idx == IDX_W'(IDX)) begin
                    r_age[c] <= i_upd.stamp;
                    if (i_upd.alloc) begin
                        r_tag[c] <= i_upd.tag;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/mesi_snoop_coherence.sv
`default_nettype none
// MESI snooping coherence for NUM_CACHES fully associative caches. Lines are
// held in a row of LINES cells, each cell holding one line of every cache; a
// lookup record walks the row one cell per cycle, and busy is high through the
// scan and apply states; a requester index at or above NUM_CACHES returns an
// all-zero result in the cycle after start. Each result is shown for exactly one
// cycle with o_valid and cannot be stalled: capture it when o_valid is high.
// The configuration channel is always ready; write it only while idle.
module mesi_snoop_coherence #(
    parameter int NUM_CACHES = msc_pkg::DEF_NUM_CACHES,
    parameter int LINES      = msc_pkg::DEF_LINES,
    parameter int ADDR_BITS  = msc_pkg::DEF_ADDR_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [1:0]  i_requester,
    input  wire logic [31:0] i_address,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_valid,
    output logic             o_hit,
    output logic [1:0]       o_old_state,
    output logic [1:0]       o_new_state,
    output logic [1:0]       o_bus_op,
    output logic             o_remote_flush,
    output logic             o_shared_copy,
    output logic [3:0]       o_invalidate_mask,
    output logic             o_writeback,
    output logic [31:0]      o_victim_tag
);
    import msc_pkg::*;

    localparam int CNT_W = $clog2(LINES);
    localparam logic [31:0] AMASK =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    t_fsm             r_fsm, n_fsm;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [OFF_W-1:0] r_off;
    logic [AGE_W-1:0] r_ctr;
    logic [AGE_W-1:0] r_stamp;
    logic [TAG_W-1:0] r_tag;
    logic             r_cmd;
    logic [1:0]       r_req;

    t_rec w_rec [LINES+1];
    t_upd w_upd;
    t_rec w_fin;

    logic  w_accept;
    logic  w_req_ok;
    logic  w_shared;
    t_mesi w_old, w_new;
    t_bus  w_bus;
    logic  w_use_min;
    logic [IDX_W-1:0] w_vidx;

    assign busy        = (r_fsm != FSM_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_req_ok    = (32'(i_requester) < 32'(NUM_CACHES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= OFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_off <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_IDLE;
            r_cnt <= '0;
            r_ctr <= '0;
        end else begin
            r_fsm <= n_fsm;
            r_cnt <= n_cnt;
            if (w_accept && w_req_ok) begin
                r_ctr <= r_ctr + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_req   <= i_requester;
            r_stamp <= r_ctr;
            r_tag   <= (i_address & AMASK) >> r_off;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        n_cnt = r_cnt;
        unique case (r_fsm)
            FSM_IDLE: begin
                n_cnt = '0;
                if (w_accept && w_req_ok) begin
                    n_fsm = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(LINES - 1)) begin
                    n_fsm = FSM_APPLY;
                end
            end
            FSM_APPLY: begin
                n_fsm = FSM_IDLE;
            end
            default: begin
                n_fsm = FSM_IDLE;
            end
        endcase
    end

    // seed of the lookup walk
    always_comb begin
        w_rec[0]         = '0;
        w_rec[0].min_age = '1;
    end

    for (genvar g = 0; g < LINES; g++) begin : g_cell
        msc_cell #(
            .NUM_CACHES(NUM_CACHES),
            .IDX       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (r_req),
            .i_tag  (r_tag),
            .i_rec  (w_rec[g]),
            .o_rec  (w_rec[g+1]),
            .i_upd  (w_upd)
        );
    end

    assign w_fin     = w_rec[LINES];
    assign w_shared  = |w_fin.match_mask;
    assign w_use_min = !w_fin.own_hit && !w_fin.inv_found;
    assign w_vidx    = w_fin.inv_found ? w_fin.inv_idx : w_fin.min_idx;

    always_comb begin
        w_old = w_fin.own_hit ? w_fin.own_state : ST_I;
        w_new = w_old;
        w_bus = BUS_NONE;
        if (r_cmd == CMD_WRITE) begin
            w_new = ST_M;
            if (!w_fin.own_hit) begin
                w_bus = BUS_RDX;
            end else if (w_old == ST_S) begin
                w_bus = BUS_UPGR;
            end
        end else if (!w_fin.own_hit) begin
            w_bus = BUS_RD;
            w_new = w_shared ? ST_S : ST_E;
        end
    end

    always_comb begin
        w_upd              = '0;
        w_upd.en           = (r_fsm == FSM_APPLY);
        w_upd.idx          = w_fin.own_hit ? w_fin.own_idx : w_vidx;
        w_upd.alloc        = !w_fin.own_hit;
        w_upd.state        = w_new;
        w_upd.tag          = r_tag;
        w_upd.stamp        = r_stamp;
        w_upd.remote_en    = (w_bus != BUS_NONE);
        w_upd.remote_state = (w_bus == BUS_RD) ? ST_S : ST_I;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_fsm == FSM_APPLY) || (w_accept && !w_req_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == FSM_APPLY) begin
            o_hit             <= w_fin.own_hit;
            o_old_state       <= w_old;
            o_new_state       <= w_new;
            o_bus_op          <= w_bus;
            o_remote_flush    <= (w_bus == BUS_RD || w_bus == BUS_RDX) && (|w_fin.m_mask);
            o_shared_copy     <= w_shared;
            o_invalidate_mask <= (w_bus == BUS_RDX || w_bus == BUS_UPGR) ?
                                 w_fin.match_mask[3:0] : 4'd0;
            o_writeback       <= w_use_min && w_fin.min_m;
            o_victim_tag      <= w_use_min ? w_fin.min_tag : '0;
        end else if (w_accept) begin
            // any accepted start clears the outputs; an out-of-range requester thus drops the access and reports zeros
            o_hit             <= 1'b0;
            o_old_state       <= ST_I;
            o_new_state       <= ST_I;
            o_bus_op          <= BUS_NONE;
            o_remote_flush    <= 1'b0;
            o_shared_copy     <= 1'b0;
            o_invalidate_mask <= 4'd0;
            o_writeback       <= 1'b0;
            o_victim_tag      <= '0;
        end
    end

endmodule
`default_nettype wire
